// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL of the servo pulse generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define MSP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define MSP_ASSERT_NEVER(label, clk, rst_n, expr) \
    `MSP_ASSERT(label, clk, rst_n, !(expr))

`endif

// File: sv/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Widths, register codes and reset values of the servo pulse generator.
// ----------------------------------------------------------------------------
package msp_pkg;

    // Item field widths
    localparam int VAL_W    = 16;
    localparam int TGT_W    = 2;
    localparam int PIN_W    = 4;
    localparam int ACH_W    = 2;

    // Channel count default and upper bound
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int NUM_CHANNELS_MAX = 16;
    // Wide enough to hold any channel number up to the bound
    localparam int CH_CMP_W = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = VAL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TICKS      = 1'b1;

    localparam logic [VAL_W-1:0] MIN_PULSE_RESET = 16'd100;
    localparam logic [VAL_W-1:0] SLOT_RESET      = 16'd200;

    // Item opcodes
    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_SET_POINT = 1'b1;

endpackage

// File: sv/msp_req_if.sv
// ----------------------------------------------------------------------------
// msp_req_if
// Request channel: timer ticks and set-point writes.
// ----------------------------------------------------------------------------
interface msp_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [msp_pkg::TGT_W-1:0]  target_channel;
    logic [msp_pkg::VAL_W-1:0]  set_point;

    modport source (output valid, output opcode, output target_channel,
                    output set_point, input ready);
    modport sink   (input valid, input opcode, input target_channel,
                    input set_point, output ready);
endinterface

// File: sv/msp_rsp_if.sv
// ----------------------------------------------------------------------------
// msp_rsp_if
// Result channel: pin levels after each item.
// ----------------------------------------------------------------------------
interface msp_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [msp_pkg::PIN_W-1:0]  pin_levels;
    logic [msp_pkg::ACH_W-1:0]  active_channel;
    logic                       frame_slot_done;

    modport source (output valid, output pin_levels, output active_channel,
                    output frame_slot_done, input ready);
    modport sink   (input valid, input pin_levels, input active_channel,
                    input frame_slot_done, output ready);
endinterface

// File: sv/multiplexed_servo_pulse_generator.sv
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_generator
// Time-multiplexed RC servo pulse generator, one channel slot at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per handshake: a timer tick (opcode tick) or a
//   set-point write to a channel's pending value. Every accepted item gives
//   exactly one item on rsp: the pin levels and active channel after that
//   item, plus a flag set when the tick closed a slot and loaded shadows.
//   The result is registered: it is valid the cycle after acceptance.
//   Throughput is one item per cycle while rsp takes each result; the single result register sets it.
//   req.ready stays high while the result register is empty or is being
//   taken in the same cycle, so a stalled rsp holds one result and blocks
//   further items until it drains.
//   cfg_we/cfg_index/cfg_data write min_pulse_ticks (index 0) and slot_ticks
//   (index 1); write them only while no item is in flight.
//   Reset clears all set-points, returns to channel 0 start phase with all
//   pins low, and restores min_pulse_ticks = 100 and slot_ticks = 200.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multiplexed_servo_pulse_generator #(
    parameter int NUM_CHANNELS = msp_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    msp_req_if.sink                         req,
    msp_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int VW   = msp_pkg::VAL_W;
    localparam int CW   = msp_pkg::CH_CMP_W;
    localparam int PW   = msp_pkg::PIN_W;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ON    = 2'd1,
        PH_OFF   = 2'd2
    } phase_t;

    // State
    logic [VW-1:0]   min_pulse_reg;
    logic [VW-1:0]   slot_reg;
    logic [VW-1:0]   shadow_reg  [NUM_CHANNELS];
    logic [VW-1:0]   pending_reg [NUM_CHANNELS];
    logic [CH_W-1:0] chan_reg, chan_next;
    phase_t          phase_reg, phase_next;
    logic [VW-1:0]   high_reg, high_next;
    logic [VW-1:0]   low_reg, low_next;
    logic [PW-1:0]   pin_reg, pin_next;
    logic            rsp_valid_reg;
    logic            done_reg, done_next;

    logic            accept;
    logic            tick;
    logic            slot_end;
    logic [CW-1:0]   chan_wide;
    logic [PW-1:0]   pin_sel;
    logic [VW:0]     on_sum;
    logic [VW-1:0]   on_val;

    // Handshake: one result register, refilled as it drains
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign tick      = accept && (req.opcode == msp_pkg::OP_TICK);

    // Pin of the current channel; channels past the pin count select none
    assign chan_wide = CW'(chan_reg);
    always_comb
    begin
        for (int i = 0; i < PW; i++)
        begin
            pin_sel[i] = (chan_wide == CW'(i));
        end
    end

    // High time capped at slot length, low time is the remainder
    assign on_sum = {1'b0, min_pulse_reg} + {1'b0, shadow_reg[chan_reg]};
    assign on_val = (on_sum > {1'b0, slot_reg}) ? slot_reg : on_sum[VW-1:0];

    // Slot sequencer
    always_comb
    begin
        chan_next  = chan_reg;
        phase_next = phase_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        pin_next   = pin_reg;
        slot_end   = 1'b0;
        if (tick)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    pin_next   = pin_reg | pin_sel;
                    high_next  = on_val;
                    low_next   = slot_reg - on_val;
                    phase_next = PH_ON;
                end
                PH_ON:
                begin
                    if (high_reg <= VW'(1))
                    begin
                        high_next  = '0;
                        pin_next   = pin_reg & ~pin_sel;
                        phase_next = PH_OFF;
                    end
                    else
                    begin
                        high_next = high_reg - VW'(1);
                    end
                end
                PH_OFF:
                begin
                    if (low_reg <= VW'(1))
                    begin
                        low_next   = '0;
                        phase_next = PH_START;
                        slot_end   = 1'b1;
                        chan_next  = (chan_reg == CH_W'(NUM_CHANNELS - 1)) ?
                                     '0 : chan_reg + CH_W'(1);
                    end
                    else
                    begin
                        low_next = low_reg - VW'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    assign done_next = slot_end;

    // Sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg      <= '0;
            phase_reg     <= PH_START;
            high_reg      <= '0;
            low_reg       <= '0;
            pin_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            chan_reg  <= chan_next;
            phase_reg <= phase_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            pin_reg   <= pin_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
                done_reg      <= done_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Set-points: pending written by items, copied to shadows at slot end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                shadow_reg[i]  <= '0;
                pending_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (accept && (req.opcode == msp_pkg::OP_SET_POINT) &&
                    (CW'(req.target_channel) == CW'(i)))
                begin
                    pending_reg[i] <= req.set_point;
                end
                if (slot_end)
                begin
                    shadow_reg[i] <= pending_reg[i];
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg <= msp_pkg::MIN_PULSE_RESET;
            slot_reg      <= msp_pkg::SLOT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                msp_pkg::CFG_MIN_PULSE_TICKS: min_pulse_reg <= cfg_data;
                msp_pkg::CFG_SLOT_TICKS:      slot_reg      <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Result payload: state only moves when the result register is free
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.pin_levels      = pin_reg;
    assign rsp.active_channel  = chan_wide[msp_pkg::ACH_W-1:0];
    assign rsp.frame_slot_done = done_reg;

    // Checks
    `MSP_ASSERT(a_one_pin_high, clk, rst_n, $onehot0(pin_reg))
    `MSP_ASSERT(a_pin_only_in_on, clk, rst_n, (pin_reg != '0) |-> (phase_reg == PH_ON))
    `MSP_ASSERT(a_chan_moves_at_slot_end, clk, rst_n,
        (chan_reg != $past(chan_reg)) |-> (rsp_valid_reg && done_reg))
    `MSP_ASSERT_NEVER(a_done_not_in_start, clk, rst_n,
        rsp_valid_reg && done_reg && (phase_reg != PH_START))

endmodule
